// File: rtl/char_lcd_nibble_bus_sequencer_defines.svh
// Assertion macros used by the checker file of the LCD nibble bus sequencer.
// No dependencies; include by bare file name.
`ifndef CHAR_LCD_NIBBLE_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_BUS_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clcd_pkg.sv
// Shared types, codes and constants of the LCD nibble bus sequencer.
// No dependencies.
`timescale 1ns / 1ps
package clcd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int STEP_W     = 5;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_SET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CTRL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_ROW     = 2'd3;

    localparam logic [7:0] RST_FUNCTION_SET = 8'h28;
    localparam logic [7:0] RST_DISPLAY_CTRL = 8'h0C;
    localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;
    localparam logic [6:0] RST_SECOND_ROW   = 7'h40;

    localparam logic [7:0] CLEAR_CODE    = 8'h01;
    localparam logic [7:0] SET_ADDR_BIT  = 8'h80;
    localparam logic [3:0] NIB_INIT      = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;

    localparam logic [5:0] POWER_ON_WAIT_MS = 6'd50;
    localparam logic [5:0] HOLD_PULSE       = 6'd1;
    localparam logic [5:0] HOLD_BYTE_END    = 6'd3;
    localparam logic [5:0] HOLD_INIT_END    = 6'd6;
    localparam logic [5:0] HOLD_CLEAR_END   = 6'd5;

    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
    localparam logic [STEP_W-1:0] PWR_BYTE_START = 5'd9;
    localparam logic [STEP_W-1:0] PWR_LAST_STEP  = 5'd24;

    typedef enum logic [1:0] {
        CMD_INSTR   = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_CURSOR  = 2'd2,
        CMD_POWERUP = 2'd3
    } t_cmd;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_POWERUP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       rs;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic [7:0] function_set;
        logic [7:0] display_ctrl;
        logic [7:0] entry_mode;
        logic [6:0] second_row;
    } t_cfg;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic [5:0] hold;
        logic       last;
    } t_phase;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/clcd_req_if.sv
// Request channel: valid/ready handshake with command and its operands.
// No dependencies.
`timescale 1ns / 1ps
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;

    modport source (output valid, command, byte_value, row, column, input ready);
    modport sink   (input valid, command, byte_value, row, column, output ready);
endinterface

// File: rtl/clcd_phase_if.sv
// Bus phase channel: valid/ready handshake with one LCD bus phase.
// No dependencies.
`timescale 1ns / 1ps
interface clcd_phase_if;
    logic       valid;
    logic       ready;
    logic       rs_level;
    logic       enable_level;
    logic [3:0] bus_nibble;
    logic [5:0] hold_ms;
    logic       last;

    modport source (output valid, rs_level, enable_level, bus_nibble, hold_ms, last,
                    input ready);
    modport sink   (input valid, rs_level, enable_level, bus_nibble, hold_ms, last,
                    output ready);
    modport monitor (input valid, ready, rs_level, enable_level, bus_nibble, hold_ms,
                     last);
endinterface

// File: rtl/clcd_queue.sv
// Short job queue between request classification and phase sequencing.
// Depends on clcd_pkg.
`timescale 1ns / 1ps
module clcd_queue
    import clcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/clcd_front.sv
// Front end: configuration registers, request accept and classification into jobs.
// Depends on clcd_pkg and clcd_req_if.
`timescale 1ns / 1ps
module clcd_front
    import clcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    clcd_req_if.sink              i_req,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_job                  o_job,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [6:0] w_row_base;
    logic [6:0] w_addr;

    assign o_cfg       = r_cfg;
    assign i_req.ready = !i_q_stat.full;
    assign o_push      = i_req.valid && i_req.ready;
    assign w_row_base  = i_req.row ? r_cfg.second_row : 7'd0;
    assign w_addr      = w_row_base + {1'b0, i_req.column};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.function_set <= RST_FUNCTION_SET;
            r_cfg.display_ctrl <= RST_DISPLAY_CTRL;
            r_cfg.entry_mode   <= RST_ENTRY_MODE;
            r_cfg.second_row   <= RST_SECOND_ROW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FUNCTION_SET: r_cfg.function_set <= i_cfg_data;
                REG_DISPLAY_CTRL: r_cfg.display_ctrl <= i_cfg_data;
                REG_ENTRY_MODE:   r_cfg.entry_mode   <= i_cfg_data;
                REG_SECOND_ROW:   r_cfg.second_row   <= i_cfg_data[6:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        o_job.kind = KIND_BYTE;
        o_job.rs   = 1'b0;
        o_job.data = i_req.byte_value;
        unique case (t_cmd'(i_req.command))
            CMD_INSTR: begin
                o_job.rs = 1'b0;
            end
            CMD_DATA: begin
                o_job.rs = 1'b1;
            end
            CMD_CURSOR: begin
                o_job.data = SET_ADDR_BIT | {1'b0, w_addr};
            end
            CMD_POWERUP: begin
                o_job.kind = KIND_POWERUP;
            end
            default: begin
                o_job.kind = KIND_BYTE;
            end
        endcase
    end

endmodule

// File: rtl/clcd_back.sv
// Back end: sequences one job at a time into bus phases behind an output register.
// Depends on clcd_pkg and clcd_phase_if.
`timescale 1ns / 1ps
module clcd_back
    import clcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_q_stat       i_q_stat,
    input  t_job          i_job,
    output logic          o_pop,
    clcd_phase_if.source  o_phase
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [STEP_W-1:0] r_step;
    t_phase            r_out;
    logic              r_out_valid;
    t_phase            w_ph;
    logic              w_slot_free;
    logic              w_load;
    logic [STEP_W-1:0] w_init_idx;
    logic [STEP_W-1:0] w_byte_idx;
    logic [7:0]        w_pwr_byte;

    assign w_slot_free = !r_out_valid || o_phase.ready;
    assign w_load      = (r_state == ST_RUN) && w_slot_free;
    assign o_pop       = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign w_init_idx  = r_step - 1'b1;
    assign w_byte_idx  = r_step - PWR_BYTE_START;

    assign o_phase.valid        = r_out_valid;
    assign o_phase.rs_level     = r_out.rs;
    assign o_phase.enable_level = r_out.en;
    assign o_phase.bus_nibble   = r_out.nib;
    assign o_phase.hold_ms      = r_out.hold;
    assign o_phase.last         = r_out.last;

    always_comb begin
        case (w_byte_idx[3:2])
            2'd0:    w_pwr_byte = i_cfg.function_set;
            2'd1:    w_pwr_byte = i_cfg.display_ctrl;
            2'd2:    w_pwr_byte = i_cfg.entry_mode;
            default: w_pwr_byte = CLEAR_CODE;
        endcase
    end

    always_comb begin
        w_ph.rs   = 1'b0;
        w_ph.en   = 1'b0;
        w_ph.nib  = 4'h0;
        w_ph.hold = HOLD_PULSE;
        w_ph.last = 1'b0;
        if (r_job.kind == KIND_BYTE) begin
            w_ph.rs   = r_job.rs;
            w_ph.en   = !r_step[0];
            w_ph.nib  = r_step[1] ? r_job.data[3:0] : r_job.data[7:4];
            w_ph.last = (r_step == BYTE_LAST_STEP);
            w_ph.hold = w_ph.last ? HOLD_BYTE_END : HOLD_PULSE;
        end else if (r_step == '0) begin
            w_ph.hold = POWER_ON_WAIT_MS;
        end else if (r_step < PWR_BYTE_START) begin
            w_ph.en   = !w_init_idx[0];
            w_ph.nib  = (w_init_idx[2:1] == 2'd3) ? NIB_4BIT : NIB_INIT;
            w_ph.hold = (w_init_idx[0] && w_init_idx[2:1] != 2'd3) ? HOLD_INIT_END
                                                                    : HOLD_PULSE;
        end else begin
            w_ph.en   = !w_byte_idx[0];
            w_ph.nib  = w_byte_idx[1] ? w_pwr_byte[3:0] : w_pwr_byte[7:4];
            w_ph.last = (r_step == PWR_LAST_STEP);
            if (w_byte_idx[1:0] == 2'd3) begin
                w_ph.hold = w_ph.last ? HOLD_CLEAR_END : HOLD_BYTE_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_load) begin
                r_out       <= w_ph;
                r_out_valid <= 1'b1;
            end else if (o_phase.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_job   <= i_job;
                        r_step  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_load) begin
                        r_step <= r_step + 1'b1;
                        if (w_ph.last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/char_lcd_nibble_bus_sequencer.sv
// Character LCD 4-bit bus sequencer: turns each request into a run of bus phases,
// each with RS, enable, nibble and hold time in ms. An instruction, data or cursor
// request gives four phases: the back end first pulls the job from the two-entry
// queue, then emits one phase per cycle while the output side is ready; the power-up
// request gives twenty-five phases. The back-end sequencer, emitting one phase per
// cycle while the output side is ready, sets the rate; the front end keeps accepting
// requests until the queue fills. Write configuration only while no request is in
// flight; the power-up bytes are read from the registers as they go out.
`timescale 1ns / 1ps
module char_lcd_nibble_bus_sequencer
    import clcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    clcd_req_if.sink              i_req,
    clcd_phase_if.source          o_phase
);

    t_q_stat w_q_stat;
    t_job    w_push_job;
    t_job    w_head_job;
    t_cfg    w_cfg;
    logic    w_push;
    logic    w_pop;

    clcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .o_cfg       (w_cfg)
    );

    clcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    clcd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_q_stat (w_q_stat),
        .i_job    (w_head_job),
        .o_pop    (w_pop),
        .o_phase  (o_phase)
    );

endmodule

// File: rtl/clcd_checker.sv
// Port-level checks on the bus phase stream, bound to the sequencer top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_bus_sequencer_defines.svh"
module clcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_rs_level,
    input logic       i_enable_level,
    input logic [3:0] i_bus_nibble,
    input logic [5:0] i_hold_ms,
    input logic       i_last
);

    // hold a stalled phase
    `CLCD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready,
        i_valid && $stable(i_rs_level) && $stable(i_enable_level) &&
        $stable(i_bus_nibble) && $stable(i_hold_ms) && $stable(i_last),
        "stalled phase changed before it was taken")
    `CLCD_ASSERT_NOW(a_pulse_high, i_clk, i_rst_n, i_valid && i_enable_level,
        i_hold_ms == 6'd1 && !i_last, "enable-high phase must be 1 ms and not final")
    `CLCD_ASSERT_NOW(a_last_low, i_clk, i_rst_n, i_valid && i_last,
        !i_enable_level, "final phase must drive enable low")
    // follow each accepted strobe with its falling phase on the same nibble
    `CLCD_ASSERT_NEXT(a_strobe_pair, i_clk, i_rst_n, i_valid && i_ready && i_enable_level,
        i_valid && !i_enable_level && i_bus_nibble == $past(i_bus_nibble),
        "enable-high phase not followed by matching low phase")

endmodule

bind char_lcd_nibble_bus_sequencer clcd_checker u_clcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_phase.valid),
    .i_ready        (o_phase.ready),
    .i_rs_level     (o_phase.rs_level),
    .i_enable_level (o_phase.enable_level),
    .i_bus_nibble   (o_phase.bus_nibble),
    .i_hold_ms      (o_phase.hold_ms),
    .i_last         (o_phase.last)
);
